### rtl/core/structured_face_connectivity_unit_defines.svh
// Assertion macros shared by the face connectivity unit.
// Setting ASSERT_OFF leaves every use empty.
`ifndef STRUCTURED_FACE_CONNECTIVITY_UNIT_DEFINES_SVH
`define STRUCTURED_FACE_CONNECTIVITY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFC_ASSERT(lbl, prop, msg)
`define SFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/core/sfc_pkg.sv
// Types, constants and helpers of the face connectivity unit.
// Used by every module and interface of the block.
package sfc_pkg;

  localparam int MAX_CELLS     = 1023;
  localparam int CELL_W        = 10;
  localparam int VERT_W        = 11;
  localparam int FACE_W        = 32;
  localparam int VERTEX_W      = 31;
  localparam int DIVISOR_W     = 21;
  localparam int DIV_STAGES    = FACE_W;
  localparam int FIFO_DEPTH    = 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int SETTLE_W      = 3;

  localparam logic [1:0] REG_CELLS_I = 2'd0;
  localparam logic [1:0] REG_CELLS_J = 2'd1;
  localparam logic [1:0] REG_CELLS_K = 2'd2;

  typedef enum logic [1:0] {
    DIR_I = 2'd0,
    DIR_J = 2'd1,
    DIR_K = 2'd2
  } dir_t;

  typedef struct packed {
    logic [CELL_W-1:0] nx;
    logic [CELL_W-1:0] ny;
    logic [CELL_W-1:0] nz;
    logic [VERT_W-1:0] vx;
    logic [VERT_W-1:0] vy;
    logic [20:0]       vxvy;
    logic [19:0]       nxny;
    logic [19:0]       nxvy;
    logic [19:0]       vxny;
    logic [29:0]       nxnynz;
    logic [FACE_W-1:0] nfi;
    logic [FACE_W-1:0] nfij;
    logic [FACE_W-1:0] tot;
  } geom_t;

  typedef struct packed {
    logic [FACE_W-1:0] g;
    dir_t              dir;
    logic              oor;
    logic              is_min;
    logic              is_max;
    logic [FACE_W-1:0] line;
    logic [19:0]       prod;
  } job_t;

  function automatic logic [CELL_W-1:0] eff_cells(input logic [CELL_W-1:0] v);
    return (v == '0) ? CELL_W'(1) : v;
  endfunction

endpackage

### rtl/core/sfc_face_if.sv
// Input channel of the face connectivity unit: one face number per beat.
// Depends on sfc_pkg.
interface sfc_face_if;
  import sfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [FACE_W-1:0] face_id;
  modport source (output valid, output face_id, input ready);
  modport sink (input valid, input face_id, output ready);
endinterface

### rtl/core/sfc_result_if.sv
// Result channel of the face connectivity unit: one connectivity record per beat.
// Depends on sfc_pkg.
interface sfc_result_if;
  import sfc_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          direction;
  logic [FACE_W-1:0]   left_parent;
  logic [FACE_W-1:0]   right_parent;
  logic [VERTEX_W-1:0] vertex_a;
  logic [VERTEX_W-1:0] vertex_b;
  logic [VERTEX_W-1:0] vertex_c;
  logic [VERTEX_W-1:0] vertex_d;
  logic                out_of_range;
  modport source (output valid, output direction, output left_parent,
                  output right_parent, output vertex_a, output vertex_b,
                  output vertex_c, output vertex_d, output out_of_range,
                  input ready);
  modport sink (input valid, input direction, input left_parent,
                input right_parent, input vertex_a, input vertex_b,
                input vertex_c, input vertex_d, input out_of_range,
                output ready);
endinterface

### rtl/core/sfc_cfg_if.sv
// Configuration write channel: register index and write data per beat.
// Depends on sfc_pkg.
interface sfc_cfg_if;
  import sfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        index;
  logic [CELL_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/sfc_cfg.sv
// Cell count registers and the derived block geometry, built over four stages.
// Depends on sfc_pkg, sfc_cfg_if and the assertion macro header.
`include "structured_face_connectivity_unit_defines.svh"
module sfc_cfg (
  input  logic           clk,
  input  logic           rst,
  sfc_cfg_if.sink        cfg,
  output sfc_pkg::geom_t geom,
  output logic           settling
);
  import sfc_pkg::*;

  logic [CELL_W-1:0]   cells_i;
  logic [CELL_W-1:0]   cells_j;
  logic [CELL_W-1:0]   cells_k;
  logic [SETTLE_W-1:0] settle;
  logic [VERT_W-1:0]   nz1;
  logic [FACE_W-1:0]   nfj;
  logic [FACE_W-1:0]   nfk;
  logic                wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid & cfg.ready;
  assign settling  = (settle != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_i <= CELL_W'(1);
      cells_j <= CELL_W'(1);
      cells_k <= CELL_W'(1);
      settle  <= SETTLE_W'(SETTLE_CYCLES);
    end else begin
      if (wr) begin
        unique case (cfg.index)
          REG_CELLS_I: cells_i <= cfg.data;
          REG_CELLS_J: cells_j <= cfg.data;
          REG_CELLS_K: cells_k <= cfg.data;
          default: ;
        endcase
        settle <= SETTLE_W'(SETTLE_CYCLES);
      end else if (settle != '0) begin
        settle <= settle - SETTLE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    geom.nx     <= eff_cells(cells_i);
    geom.ny     <= eff_cells(cells_j);
    geom.nz     <= eff_cells(cells_k);
    geom.vx     <= VERT_W'(eff_cells(cells_i)) + VERT_W'(1);
    geom.vy     <= VERT_W'(eff_cells(cells_j)) + VERT_W'(1);
    nz1         <= VERT_W'(eff_cells(cells_k)) + VERT_W'(1);
    geom.vxvy   <= 21'(geom.vx) * 21'(geom.vy);
    geom.nxny   <= 20'(geom.nx) * 20'(geom.ny);
    geom.nxvy   <= 20'(geom.nx) * 20'(geom.vy);
    geom.vxny   <= 20'(geom.vx) * 20'(geom.ny);
    geom.nfi    <= 32'(geom.vxny) * 32'(geom.nz);
    nfj         <= 32'(geom.nxvy) * 32'(geom.nz);
    nfk         <= 32'(geom.nxny) * 32'(nz1);
    geom.nxnynz <= 30'(geom.nxny) * 30'(geom.nz);
    geom.nfij   <= geom.nfi + nfj;
    geom.tot    <= geom.nfi + nfj + nfk;
  end

  `SFC_ASSERT(a_cfg_settle, wr |=> settling, "configuration write did not hold off faces")
  `SFC_ASSERT(a_cfg_count, settle <= SETTLE_W'(SETTLE_CYCLES), "settle count out of range")

endmodule

### rtl/core/sfc_div.sv
// Pipelined restoring divider, one quotient bit per stage, advancing on en.
// Depends on sfc_pkg.
module sfc_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [sfc_pkg::FACE_W-1:0]    num,
  input  logic [sfc_pkg::DIVISOR_W-1:0] den,
  output logic [sfc_pkg::FACE_W-1:0]    quo,
  output logic [sfc_pkg::DIVISOR_W-1:0] rem
);
  import sfc_pkg::*;

  logic [DIVISOR_W-1:0] rem_r [DIV_STAGES];
  logic [FACE_W-1:0]    quo_r [DIV_STAGES];
  logic [FACE_W-1:0]    num_r [DIV_STAGES];
  logic [DIVISOR_W-1:0] den_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIVISOR_W-1:0] rem_in;
    logic [FACE_W-1:0]    quo_in;
    logic [FACE_W-1:0]    num_in;
    logic [DIVISOR_W-1:0] den_in;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign num_in = num_r[s-1];
      assign den_in = den_r[s-1];
    end

    assign trial = {rem_in, num_in[FACE_W-1]};
    assign ge    = (trial >= {1'b0, den_in});
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_r[s] <= {quo_in[FACE_W-2:0], ge};
        num_r[s] <= {num_in[FACE_W-2:0], 1'b0};
        den_r[s] <= den_in;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];
  assign rem = rem_r[DIV_STAGES-1];

endmodule

### rtl/core/sfc_fifo.sv
// Short job queue between the classifying front and the result back end.
// Depends on sfc_pkg and the assertion macro header.
`include "structured_face_connectivity_unit_defines.svh"
module sfc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfc_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output sfc_pkg::job_t rdata,
  output logic          empty
);
  import sfc_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  job_t          mem [FIFO_DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [CW-1:0] count;

  assign full  = (count == CW'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(FIFO_DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (pop) begin
        rp <= (rp == AW'(FIFO_DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `SFC_ASSERT(a_fifo_bound, count <= CW'(FIFO_DEPTH), "queue count past its depth")
  `SFC_ASSERT(a_fifo_grow, (push && !pop) |=> (count == $past(count) + CW'(1)),
              "queue count missed a push")

endmodule

### rtl/core/sfc_front.sv
// Front end: takes face numbers, classifies them, divides and forms products.
// Depends on sfc_pkg, sfc_face_if, sfc_div and the assertion macro header.
`include "structured_face_connectivity_unit_defines.svh"
module sfc_front (
  input  logic           clk,
  input  logic           rst,
  sfc_face_if.sink       face,
  input  sfc_pkg::geom_t geom,
  input  logic           settling,
  input  logic           full,
  output logic           push,
  output sfc_pkg::job_t  job
);
  import sfc_pkg::*;

  logic                 en;
  logic                 v0;
  logic [FACE_W-1:0]    f0;
  logic                 v1;
  dir_t                 dir1;
  logic                 oor1;
  logic [FACE_W-1:0]    g1;
  logic [DIVISOR_W-1:0] den_a1;
  logic [DIVISOR_W-1:0] den_b1;
  dir_t                 dir_c;
  logic [FACE_W-1:0]    off_c;
  logic                 dv   [DIV_STAGES];
  dir_t                 ddir [DIV_STAGES];
  logic                 door [DIV_STAGES];
  logic [FACE_W-1:0]    dg   [DIV_STAGES];
  logic [FACE_W-1:0]    quo_a;
  logic [FACE_W-1:0]    quo_b;
  logic [DIVISOR_W-1:0] rem_a;
  logic [DIVISOR_W-1:0] rem_b;
  logic                 v2;
  logic [CELL_W-1:0]    plane;
  dir_t                 dir_l;
  logic [FACE_W-1:0]    g_l;

  assign en         = !(v2 && full);
  assign face.ready = en && !settling;
  assign push       = v2 && !full;

  always_comb begin
    if (f0 <= geom.nfi) begin
      dir_c = DIR_I;
      off_c = '0;
    end else if (f0 <= geom.nfij) begin
      dir_c = DIR_J;
      off_c = geom.nfi;
    end else begin
      dir_c = DIR_K;
      off_c = geom.nfij;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0   <= face.face_id;
      dir1 <= dir_c;
      oor1 <= (f0 == '0) || (f0 > geom.tot);
      g1   <= f0 - off_c;
      unique case (dir_c)
        DIR_I: begin
          den_a1 <= DIVISOR_W'(geom.vx);
          den_b1 <= DIVISOR_W'(geom.vxny);
        end
        DIR_J: begin
          den_a1 <= DIVISOR_W'(geom.nx);
          den_b1 <= DIVISOR_W'(geom.nxvy);
        end
        default: begin
          den_a1 <= DIVISOR_W'(geom.nx);
          den_b1 <= DIVISOR_W'(geom.nxny);
        end
      endcase
    end
  end

  sfc_div u_div_line (
    .clk (clk),
    .en  (en),
    .num (g1 - FACE_W'(1)),
    .den (den_a1),
    .quo (quo_a),
    .rem (rem_a)
  );

  sfc_div u_div_plane (
    .clk (clk),
    .en  (en),
    .num (g1 - FACE_W'(1)),
    .den (den_b1),
    .quo (quo_b),
    .rem (rem_b)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ddir[0] <= dir1;
      door[0] <= oor1;
      dg[0]   <= g1;
      for (int s = 1; s < DIV_STAGES; s++) begin
        ddir[s] <= ddir[s-1];
        door[s] <= door[s-1];
        dg[s]   <= dg[s-1];
      end
    end
  end

  assign plane = quo_b[CELL_W-1:0];
  assign dir_l = ddir[DIV_STAGES-1];
  assign g_l   = dg[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      job.g    <= g_l;
      job.dir  <= dir_l;
      job.oor  <= door[DIV_STAGES-1];
      job.line <= quo_a;
      unique case (dir_l)
        DIR_I: begin
          job.prod   <= 20'(geom.vx) * 20'(plane);
          job.is_min <= (rem_a == '0);
          job.is_max <= (rem_a == DIVISOR_W'(geom.vx - VERT_W'(1)));
        end
        DIR_J: begin
          job.prod   <= 20'(geom.nx) * 20'(plane);
          job.is_min <= (rem_b < DIVISOR_W'(geom.nx));
          job.is_max <= (rem_b >= DIVISOR_W'(geom.nxny));
        end
        default: begin
          job.prod   <= 20'(geom.vx) * 20'(plane);
          job.is_min <= (g_l <= FACE_W'(geom.nxny));
          job.is_max <= (g_l > FACE_W'(geom.nxnynz));
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv[s] <= 1'b0;
      end
    end else if (en) begin
      v0    <= face.valid && face.ready;
      v1    <= v0;
      dv[0] <= v1;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dv[s] <= dv[s-1];
      end
      v2 <= dv[DIV_STAGES-1];
    end
  end

  `SFC_ASSERT(a_front_hold, (v2 && full) |=> v2, "stalled job dropped before the queue")

endmodule

### rtl/core/sfc_back.sv
// Back end: turns queued jobs into parent cells and corner vertices.
// Depends on sfc_pkg and sfc_result_if.
module sfc_back (
  input  logic           clk,
  input  logic           rst,
  input  sfc_pkg::geom_t geom,
  input  sfc_pkg::job_t  job,
  input  logic           empty,
  output logic           pop,
  sfc_result_if.source   result
);
  import sfc_pkg::*;

  logic              take;
  logic [FACE_W-1:0] base;
  logic [FACE_W-1:0] n1;
  logic [FACE_W-1:0] lsub;
  logic [FACE_W-1:0] p;
  logic [FACE_W-1:0] q;
  logic [FACE_W-1:0] vb;
  logic [FACE_W-1:0] vc;
  logic [FACE_W-1:0] vd;

  assign take = !result.valid || result.ready;
  assign pop  = take && !empty;

  always_comb begin
    unique case (job.dir)
      DIR_I: begin
        base = job.g - job.line + geom.tot;
        n1   = job.g + FACE_W'(job.prod);
        lsub = FACE_W'(1);
        p    = FACE_W'(geom.vx);
        q    = FACE_W'(geom.vxvy);
      end
      DIR_J: begin
        base = job.g - FACE_W'(job.prod) + geom.tot;
        n1   = job.g + job.line;
        lsub = FACE_W'(geom.nx);
        p    = FACE_W'(geom.vxvy);
        q    = FACE_W'(1);
      end
      default: begin
        base = job.g + geom.tot;
        n1   = job.g + job.line + FACE_W'(job.prod);
        lsub = FACE_W'(geom.nxny);
        p    = FACE_W'(1);
        q    = FACE_W'(geom.vx);
      end
    endcase
    vb = job.is_min ? n1 + q : n1 + p;
    vd = job.is_min ? n1 + p : n1 + q;
    vc = n1 + p + q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.out_of_range <= job.oor;
      if (job.oor) begin
        result.direction    <= '0;
        result.left_parent  <= '0;
        result.right_parent <= '0;
        result.vertex_a     <= '0;
        result.vertex_b     <= '0;
        result.vertex_c     <= '0;
        result.vertex_d     <= '0;
      end else begin
        result.direction    <= job.dir;
        result.left_parent  <= job.is_min ? base : base - lsub;
        result.right_parent <= (!job.is_min && !job.is_max) ? base : '0;
        result.vertex_a     <= n1[VERTEX_W-1:0];
        result.vertex_b     <= vb[VERTEX_W-1:0];
        result.vertex_c     <= vc[VERTEX_W-1:0];
        result.vertex_d     <= vd[VERTEX_W-1:0];
      end
    end
  end

endmodule

### rtl/core/structured_face_connectivity_unit.sv
// Face connectivity of a structured hexahedral block.
// The face channel takes one one-based global face number per beat; the result
// channel gives its normal axis, left and right parent cells offset by the
// total face count, four corner vertices and an out-of-range flag.
// The cfg channel writes the cell counts per axis (index 0 i, 1 j, 2 k) and is
// always ready; a count of zero acts as one.
// Throughput is one face per cycle while the geometry is not settling and the
// queue is not full; the front end holds two 32-stage dividers.
// After reset and after each configuration write the face channel holds ready
// low while the derived geometry settles.
// When the receiver stalls, results wait in the output register and a
// four-entry queue; the front pipeline then freezes and drops face ready.
// Depends on sfc_pkg, the channel interfaces and the sfc_* modules.
module structured_face_connectivity_unit (
  input  logic         clk,
  input  logic         rst,
  sfc_face_if.sink     face,
  sfc_result_if.source result,
  sfc_cfg_if.sink      cfg
);
  import sfc_pkg::*;

  geom_t geom;
  job_t  job_in;
  job_t  job_out;
  logic  settling;
  logic  full;
  logic  empty;
  logic  push;
  logic  pop;

  sfc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .geom     (geom),
    .settling (settling)
  );

  sfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .face     (face),
    .geom     (geom),
    .settling (settling),
    .full     (full),
    .push     (push),
    .job      (job_in)
  );

  sfc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (pop),
    .rdata (job_out),
    .empty (empty)
  );

  sfc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .geom   (geom),
    .job    (job_out),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

### tb/sfc_checker.sv
// Scoreboard of the face connectivity unit: tracks the cell-count registers,
// predicts the connectivity record of every accepted face and compares results.
// Depends on sfc_pkg and the face, result and cfg channel interfaces.
module sfc_checker (
  input  logic   clk,
  input  logic   rst,
  sfc_face_if    face,
  sfc_result_if  result,
  sfc_cfg_if     cfg,
  output int     errors,
  output int     pending
);
  import sfc_pkg::*;

  typedef struct packed {
    logic [1:0]          direction;
    logic [FACE_W-1:0]   left_parent;
    logic [FACE_W-1:0]   right_parent;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
    logic [VERTEX_W-1:0] vertex_c;
    logic [VERTEX_W-1:0] vertex_d;
    logic                out_of_range;
  } conn_t;

  logic [CELL_W-1:0] cnt_i, cnt_j, cnt_k;
  conn_t             expected_conn[$];

  function automatic conn_t face_connectivity(input logic [CELL_W-1:0] ci,
                                              input logic [CELL_W-1:0] cj,
                                              input logic [CELL_W-1:0] ck,
                                              input logic [FACE_W-1:0] fid);
    longint unsigned nx, ny, nz, vx, vy, nfi, nfj, total, f, g, nb, ln, pl, r, n1, base;
    longint unsigned lp, rp, a, b, c, d;
    bit lo, hi;
    conn_t res;
    nx = (ci == 0) ? 1 : ci;
    ny = (cj == 0) ? 1 : cj;
    nz = (ck == 0) ? 1 : ck;
    vx = nx + 1;
    vy = ny + 1;
    nfi = vx * ny * nz;
    nfj = vy * nx * nz;
    total = nfi + nfj + (nz + 1) * nx * ny;
    f = fid;
    res = '0;
    if (f == 0 || f > total) begin
      res.out_of_range = 1'b1;
      return res;
    end
    if (f <= nfi) begin
      g = f;
      ln = (g - 1) / vx;
      pl = (g - 1) / (vx * ny);
      r = g % vx;
      lo = (r == 1);
      hi = (r == 0);
      base = g - ln + total;
      n1 = g + pl * vx;
      res.direction = DIR_I;
      lp = lo ? base : base - 1;
      rp = (!lo && !hi) ? base : 0;
      a = n1;
      c = n1 + vx + vx * vy;
      b = lo ? n1 + vx * vy : n1 + vx;
      d = lo ? n1 + vx : n1 + vx * vy;
    end else if (f <= nfi + nfj) begin
      g = f - nfi;
      nb = vy * nx;
      ln = (g - 1) / nx;
      pl = (g - 1) / nb;
      r = g - pl * nb;
      lo = (r < vx);
      hi = (r > nb - vx + 1);
      base = g - nx * pl + total;
      n1 = g + ln;
      res.direction = DIR_J;
      lp = lo ? base : base - nx;
      rp = (!lo && !hi) ? base : 0;
      a = n1;
      c = n1 + vx * vy + 1;
      b = lo ? n1 + 1 : n1 + vx * vy;
      d = lo ? n1 + vx * vy : n1 + 1;
    end else begin
      g = f - nfi - nfj;
      nb = nx * ny;
      ln = (g - 1) / nx;
      pl = (g - 1) / nb;
      lo = (g <= nb);
      hi = (g > nb * nz);
      n1 = g + ln + vx * pl;
      res.direction = DIR_K;
      lp = lo ? g + total : g - nb + total;
      rp = (!lo && !hi) ? g + total : 0;
      a = n1;
      c = n1 + vx + 1;
      b = lo ? n1 + vx : n1 + 1;
      d = lo ? n1 + 1 : n1 + vx;
    end
    res.left_parent  = lp[31:0];
    res.right_parent = rp[31:0];
    res.vertex_a     = a[30:0];
    res.vertex_b     = b[30:0];
    res.vertex_c     = c[30:0];
    res.vertex_d     = d[30:0];
    return res;
  endfunction

  function automatic int field_diff(input string name, input longint unsigned exp_v,
                                    input longint unsigned act_v);
    if (exp_v == act_v) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
    return 1;
  endfunction

  assign pending = expected_conn.size();

  always @(posedge clk) begin
    conn_t want;
    int bad;
    if (rst) begin
      cnt_i <= CELL_W'(1);
      cnt_j <= CELL_W'(1);
      cnt_k <= CELL_W'(1);
      errors <= 0;
      expected_conn.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_CELLS_I: cnt_i <= cfg.data;
          REG_CELLS_J: cnt_j <= cfg.data;
          REG_CELLS_K: cnt_k <= cfg.data;
          default: ;
        endcase
      end
      if (face.valid && face.ready)
        expected_conn.push_back(face_connectivity(cnt_i, cnt_j, cnt_k, face.face_id));
      if (result.valid && result.ready) begin
        if (expected_conn.size() == 0) begin
          $display("%0t: result beat with no face outstanding", $realtime);
          errors <= errors + 1;
        end else begin
          want = expected_conn.pop_front();
          bad = field_diff("direction", want.direction, result.direction)
              + field_diff("left_parent", want.left_parent, result.left_parent)
              + field_diff("right_parent", want.right_parent, result.right_parent)
              + field_diff("vertex_a", want.vertex_a, result.vertex_a)
              + field_diff("vertex_b", want.vertex_b, result.vertex_b)
              + field_diff("vertex_c", want.vertex_c, result.vertex_c)
              + field_diff("vertex_d", want.vertex_d, result.vertex_d)
              + field_diff("out_of_range", want.out_of_range, result.out_of_range);
          if (bad != 0) errors <= errors + 1;
        end
      end
    end
  end

endmodule

### tb/tb_top.sv
// Top of the face connectivity testbench: clock, reset, face and cfg stimulus,
// random result back-pressure and the final verdict.
// Depends on sfc_pkg, the channel interfaces, sfc_checker and the unit itself.
module tb_top;
  import sfc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 45;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  int   cycles = 0;
  int   result_stall;
  bit   calm;
  longint unsigned nfi, nfij, total;

  sfc_face_if   face();
  sfc_result_if result();
  sfc_cfg_if    cfg();

  structured_face_connectivity_unit dut (
    .clk(clk), .rst(rst), .face(face.sink), .result(result.source), .cfg(cfg.sink)
  );

  sfc_checker chk (
    .clk(clk), .rst(rst), .face(face), .result(result), .cfg(cfg),
    .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 0;
    end else if (result.valid && result.ready) begin
      result_stall <= calm ? 0 : $urandom_range(0, 10);
    end else if (result_stall > 0) begin
      result_stall <= result_stall - 1;
    end
  end

  always @(negedge clk) begin
    result.ready <= !rst && (result_stall == 0);
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic write_cells(input logic [1:0] idx, input logic [CELL_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic configure(input logic [CELL_W-1:0] ci, input logic [CELL_W-1:0] cj,
                           input logic [CELL_W-1:0] ck);
    longint unsigned nx, ny, nz;
    write_cells(REG_CELLS_I, ci);
    write_cells(REG_CELLS_J, cj);
    write_cells(REG_CELLS_K, ck);
    nx = (ci == 0) ? 1 : ci;
    ny = (cj == 0) ? 1 : cj;
    nz = (ck == 0) ? 1 : ck;
    nfi   = (nx + 1) * ny * nz;
    nfij  = nfi + (ny + 1) * nx * nz;
    total = nfij + (nz + 1) * nx * ny;
  endtask

  task automatic send_face(input logic [FACE_W-1:0] fid);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      face.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    face.valid   <= 1'b1;
    face.face_id <= fid;
    do @(posedge clk); while (!face.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    face.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [FACE_W-1:0] pick_face();
    longint unsigned edges[8];
    int mode;
    edges = '{1, nfi, nfi + 1, nfij, nfij + 1, total, total - 1, 2};
    mode = $urandom_range(0, 9);
    if (mode < 6) return FACE_W'(({$urandom, $urandom} % total) + 1);
    if (mode < 8) return FACE_W'(edges[$urandom_range(0, 7)]);
    if (mode == 8 && total < 64'hFFFF_FFFF)
      return FACE_W'(total + 1 + ({$urandom, $urandom} % (64'hFFFF_FFFF - total)));
    return $urandom;
  endfunction

  task automatic run_phase(input logic [CELL_W-1:0] ci, input logic [CELL_W-1:0] cj,
                           input logic [CELL_W-1:0] ck, input int count, input bit directed);
    configure(ci, cj, ck);
    calm = ($urandom_range(0, 3) == 0);
    if (directed) begin
      send_face(FACE_W'(1));
      send_face(FACE_W'(nfi));
      send_face(FACE_W'(nfi + 1));
      send_face(FACE_W'(nfij));
      send_face(FACE_W'(nfij + 1));
      send_face(FACE_W'(total));
      send_face(FACE_W'(total + 1));
      send_face('0);
      send_face('1);
    end
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        face.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        calm = !calm;
      end
      send_face(pick_face());
    end
    wait_idle();
  endtask

  initial begin
    face.valid   = 1'b0;
    face.face_id = '0;
    cfg.valid    = 1'b0;
    cfg.index    = REG_CELLS_I;
    cfg.data     = '0;
    calm         = 1'b0;
    nfi = 1 * 2; nfij = 4; total = 6;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    run_phase(CELL_W'(1), CELL_W'(1), CELL_W'(1), 30, 1'b1);
    run_phase(CELL_W'(MAX_CELLS), CELL_W'(MAX_CELLS), CELL_W'(MAX_CELLS), 60, 1'b1);
    run_phase('0, CELL_W'(5), CELL_W'(MAX_CELLS), 50, 1'b1);
    run_phase(CELL_W'(MAX_CELLS), '0, CELL_W'(2), 50, 1'b0);
    run_phase(CELL_W'(2), CELL_W'(MAX_CELLS), '0, 50, 1'b0);
    for (int p = 0; p < 5; p++)
      run_phase(CELL_W'($urandom_range(1, 12)), CELL_W'($urandom_range(1, 12)),
                CELL_W'($urandom_range(0, 12)), 40, 1'b0);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
